[design/integer_text_parser_macros.svh]
// Assertion macros used by the integer text parser top level.
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("itp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("itp assertion failed");

`endif

[design/itp_pkg.sv]
// Shared types and constants of the integer text parser.
package itp_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned BASE_W  = 6;
	localparam int unsigned DIGIT_W = 6;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	// Digit value that marks a non-digit character
	localparam logic [DIGIT_W-1:0] NON_DIGIT = 6'd36;

	// Radix codes
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

	// Register index of the radix register
	localparam logic REG_NUMBER_BASE = 1'b0;

	// One classified character, as handed from front to back
	typedef struct packed {
		logic [DIGIT_W-1:0] dval;
		logic               blank;
		logic               sign;
		logic               minus;
		logic               zero;
		logic               xch;
	} ch_class_t;

	// Front-to-back queue head
	typedef struct packed {
		logic      valid;
		ch_class_t item;
	} cls_head_t;

endpackage

[design/integer_text_parser.sv]
// Top level of the integer text parser: config register, front, back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------
//  input     | push / full          | ch[7:0]
//  result    | empty / pop          | value[63:0], end_offset[15:0]
//  config    | psel penable pwrite  | paddr[2:0], pwdata, prdata
//
// One character per cycle while the result queue has room; the back end's
// 64x6 multiply-add on the accumulator sets the per-character path. A
// result reaches the result ports once the back end takes its terminating
// character from the front queue. Each side has a two-entry queue,
// so a stalled pop holds the back end only once its result queue is full.
// Reset clears all queues and the parse state and loads radix 10.
`include "integer_text_parser_macros.svh"
module integer_text_parser import itp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         ch,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output logic [VALUE_W-1:0] value,
	output logic [COUNT_W-1:0] end_offset,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [BASE_W-1:0] base_q;
	logic              cfg_wr;
	cls_head_t         head;
	logic              take;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_wr && paddr[2] == REG_NUMBER_BASE) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	// Return the register on read
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NUMBER_BASE) begin
			prdata = {{(32-BASE_W){1'b0}}, base_q};
		end
	end

	itp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ch     (ch),
		.full   (full),
		.head   (head),
		.take   (take)
	);

	itp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_base (base_q),
		.head        (head),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.value       (value),
		.end_offset  (end_offset)
	);

	// Back end only takes a queued class
	`ITP_ASSERT_IMP(a_take_needs_item, clk, arst_n, take, head.valid)
	// A take always leaves room for the next request
	`ITP_ASSERT_NXT(a_take_frees_slot, clk, arst_n, take, !full)
	// Writes to other addresses leave the radix alone
	`ITP_ASSERT_NXT(a_cfg_other_stable, clk, arst_n, cfg_wr && paddr[2] != REG_NUMBER_BASE, $stable(base_q))

endmodule

[design/itp_front.sv]
// Front end: accepts characters, classifies them and queues the classes.
module itp_front import itp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic [7:0] ch,
	output logic      full,
	output cls_head_t head,
	input  logic      take
);

	localparam int unsigned DEPTH = 2;

	ch_class_t  cls;
	ch_class_t  slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	// Classify the incoming character
	always_comb begin
		cls.dval = NON_DIGIT;
		if (ch >= CH_DIG0 && ch <= CH_DIG9) begin
			cls.dval = 6'(ch - CH_DIG0);
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			cls.dval = 6'(ch - CH_LA + 8'd10);
		end else if (ch >= CH_UA && ch <= CH_UZ) begin
			cls.dval = 6'(ch - CH_UA + 8'd10);
		end
		cls.blank = (ch == CH_SPACE) || (ch == CH_TAB);
		cls.sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
		cls.minus = (ch == CH_MINUS);
		cls.zero  = (ch == CH_DIG0);
		cls.xch   = (ch == CH_LX) || (ch == CH_UX);
	end

	assign full    = (cnt_q == 2'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = take && (cnt_q != 2'd0);

	// Store classes in arrival order
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

endmodule

[design/itp_back.sv]
// Back end: runs the parse state machine and queues finished results.
module itp_back import itp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BASE_W-1:0]   number_base,
	input  cls_head_t           head,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output logic [VALUE_W-1:0]  value,
	output logic [COUNT_W-1:0]  end_offset
);

	localparam logic [1:0] PH_BLANK  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_ZERO   = 2'd2;
	localparam logic [1:0] PH_DIGITS = 2'd3;
	localparam int unsigned DEPTH = 2;

	logic [1:0]         phase_q, phase_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic               neg_q, neg_d;
	logic [BASE_W-1:0]  base_q, base_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               emit;

	logic [BASE_W-1:0]  first_base;
	logic [BASE_W-1:0]  take_base;
	logic [VALUE_W-1:0] prod;
	logic [VALUE_W-1:0] acc_next;
	logic [COUNT_W-1:0] cnt_inc;
	logic               is_digit;

	logic [VALUE_W-1:0] oval_q [DEPTH];
	logic [COUNT_W-1:0] ooff_q [DEPTH];
	logic               owr_q;
	logic               ord_q;
	logic [1:0]         ocnt_q;
	logic               ofull;
	logic               do_pop;

	assign ofull  = (ocnt_q == 2'(DEPTH));
	assign take   = head.valid && !ofull;
	assign do_pop = pop && !empty;

	// Pick the radix for this character
	always_comb begin
		first_base = (phase_q == PH_BLANK) ? number_base : base_q;
		case (phase_q)
			PH_ZERO:   take_base = (base_q == BASE_AUTO) ? BASE_OCT : base_q;
			PH_DIGITS: take_base = base_q;
			default:   take_base = (first_base == BASE_AUTO) ? BASE_DEC : first_base;
		endcase
	end

	// Multiply-add one digit and bump the saturating count
	assign prod     = acc_q * {{(VALUE_W-BASE_W){1'b0}}, take_base};
	assign acc_next = prod + {{(VALUE_W-DIGIT_W){1'b0}}, head.item.dval};
	assign cnt_inc  = (cnt_q == {COUNT_W{1'b1}}) ? cnt_q : cnt_q + 16'd1;
	assign is_digit = (head.item.dval != NON_DIGIT) && (head.item.dval < take_base);

	// Next parse state
	always_comb begin
		logic do_take;
		logic do_first;
		phase_d  = phase_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		base_d   = base_q;
		cnt_d    = cnt_q;
		emit     = 1'b0;
		do_take  = 1'b0;
		do_first = 1'b0;
		case (phase_q)
			PH_BLANK: begin
				if (head.item.blank) begin
					cnt_d = cnt_inc;
				end else if (head.item.sign) begin
					neg_d   = head.item.minus;
					cnt_d   = cnt_inc;
					phase_d = PH_SIGN;
					base_d  = number_base;
				end else begin
					do_first = 1'b1;
				end
			end
			PH_SIGN: begin
				do_first = 1'b1;
			end
			PH_ZERO: begin
				if (head.item.xch) begin
					base_d  = BASE_HEX;
					cnt_d   = cnt_inc;
					phase_d = PH_DIGITS;
				end else begin
					do_take = 1'b1;
				end
			end
			default: begin
				do_take = 1'b1;
			end
		endcase
		if (do_first) begin
			if ((first_base == BASE_AUTO || first_base == BASE_HEX) && head.item.zero) begin
				cnt_d   = cnt_inc;
				phase_d = PH_ZERO;
				base_d  = first_base;
			end else begin
				do_take = 1'b1;
			end
		end
		if (do_take) begin
			if (is_digit) begin
				acc_d   = acc_next;
				cnt_d   = cnt_inc;
				base_d  = take_base;
				phase_d = PH_DIGITS;
			end else begin
				emit    = 1'b1;
				phase_d = PH_BLANK;
				acc_d   = '0;
				neg_d   = 1'b0;
				base_d  = BASE_AUTO;
				cnt_d   = '0;
			end
		end
	end

	// Advance the parse state on each taken character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= BASE_AUTO;
			cnt_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
		end
	end

	// Hold finished results until popped
	always_ff @(posedge clk) begin
		if (take && emit) begin
			oval_q[owr_q] <= neg_q ? ({VALUE_W{1'b0}} - acc_q) : acc_q;
			ooff_q[owr_q] <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (take && emit) begin
				owr_q <= ~owr_q;
			end
			if (do_pop) begin
				ord_q <= ~ord_q;
			end
			if ((take && emit) && !do_pop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (do_pop && !(take && emit)) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	assign empty      = (ocnt_q == 2'd0);
	assign value      = oval_q[ord_q];
	assign end_offset = ooff_q[ord_q];

endmodule

[sim/itp_result_checker.sv]
// Checker for the integer text parser: predicts each parsed number and compares results.
module itp_result_checker import itp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         ch,
	input  logic               full,
	input  logic               empty,
	input  logic               pop,
	input  logic [VALUE_W-1:0] value,
	input  logic [COUNT_W-1:0] end_offset,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {SCAN_BLANK, SCAN_SIGN, SCAN_ZERO, SCAN_DIGITS} scan_phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] offset;
	} parsed_number_t;

	parsed_number_t     expected_numbers[$];
	logic [BASE_W-1:0]  base_reg = BASE_RESET;
	logic [BASE_W-1:0]  radix    = BASE_AUTO;
	scan_phase_t        scan     = SCAN_BLANK;
	logic [VALUE_W-1:0] acc      = '0;
	logic               neg      = 1'b0;
	logic [COUNT_W-1:0] consumed = '0;
	int                 error_count   = 0;
	int                 pending_count = 0;

	assign mismatches  = error_count;
	assign outstanding = pending_count;

	// Map a character to its digit value, or the non-digit marker
	function automatic logic [DIGIT_W-1:0] char_digit(input logic [7:0] c);
		if (c >= CH_DIG0 && c <= CH_DIG9)
			return DIGIT_W'(c - CH_DIG0);
		if (c >= CH_LA && c <= CH_LZ)
			return DIGIT_W'(c - CH_LA + 8'd10);
		if (c >= CH_UA && c <= CH_UZ)
			return DIGIT_W'(c - CH_UA + 8'd10);
		return NON_DIGIT;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < 20)
			$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Count one consumed character, saturating
	task automatic bump_count();
		if (consumed != '1)
			consumed++;
	endtask

	task automatic clear_scan();
		scan     = SCAN_BLANK;
		acc      = '0;
		neg      = 1'b0;
		radix    = BASE_AUTO;
		consumed = '0;
	endtask

	// Accumulate a digit, or close the number and queue its expected result
	task automatic take_digit(input logic [7:0] c);
		logic [DIGIT_W-1:0] d;
		parsed_number_t     n;
		d = char_digit(c);
		if (d != NON_DIGIT && d < radix) begin
			acc = acc * VALUE_W'(radix) + VALUE_W'(d);
			bump_count();
		end else begin
			n.value  = neg ? -acc : acc;
			n.offset = consumed;
			expected_numbers.push_back(n);
			clear_scan();
		end
	endtask

	// Advance the parse state by one character
	task automatic scan_char(input logic [7:0] c);
		if (scan == SCAN_BLANK) begin
			radix = base_reg;
			if (c == CH_SPACE || c == CH_TAB) begin
				bump_count();
				return;
			end
			if (c == CH_MINUS || c == CH_PLUS) begin
				neg = (c == CH_MINUS);
				bump_count();
				scan = SCAN_SIGN;
				return;
			end
			scan = SCAN_SIGN;
		end
		if (scan == SCAN_SIGN) begin
			if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_DIG0) begin
				bump_count();
				scan = SCAN_ZERO;
				return;
			end
			if (radix == BASE_AUTO)
				radix = BASE_DEC;
			scan = SCAN_DIGITS;
			take_digit(c);
			return;
		end
		if (scan == SCAN_ZERO) begin
			scan = SCAN_DIGITS;
			if (c == CH_LX || c == CH_UX) begin
				radix = BASE_HEX;
				bump_count();
				return;
			end
			if (radix == BASE_AUTO)
				radix = BASE_OCT;
		end
		take_digit(c);
	endtask

	// Watch the register port, the result side and the request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = BASE_RESET;
			clear_scan();
			expected_numbers.delete();
			pending_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_NUMBER_BASE)
				base_reg = pwdata[BASE_W-1:0];
			if (pop && !empty) begin
				if (expected_numbers.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d offset %0d",
						$signed(value), end_offset));
				end else begin
					if (value !== expected_numbers[0].value)
						report_mismatch($sformatf("value %0d, expected %0d", $signed(value),
							$signed(expected_numbers[0].value)));
					if (end_offset !== expected_numbers[0].offset)
						report_mismatch($sformatf("end_offset %0d, expected %0d", end_offset,
							expected_numbers[0].offset));
					void'(expected_numbers.pop_front());
				end
			end
			if (push && !full)
				scan_char(ch);
			pending_count <= expected_numbers.size();
		end
	end

endmodule

[sim/tb_integer_text_parser.sv]
// Testbench top for the integer text parser: clock, reset, character stimulus and verdict.
module tb_integer_text_parser import itp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         SPARE_INDEX = 1;
	localparam logic [2:0] BASE_ADDR   = 3'(int'(REG_NUMBER_BASE) * 4);
	localparam logic [2:0] SPARE_ADDR  = 3'(SPARE_INDEX * 4);
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_COMMA    = 8'h2C;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic [7:0]         ch;
	logic               full;
	logic               empty;
	logic               pop;
	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] end_offset;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int                 hold_len  = 0;
	int                 chars_sent = 0;

	integer_text_parser i_dut (
		.clk, .arst_n, .push, .ch, .full, .empty, .pop, .value, .end_offset,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	itp_result_checker i_checker (
		.clk, .arst_n, .push, .ch, .full, .empty, .pop, .value, .end_offset,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatches, .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Bound the run
	initial begin
		#8ms;
		$display("integer_text_parser test failed");
		$finish;
	end

	// Offer one character, idling at random first; return once it is taken
	task automatic send_char(input logic [7:0] c);
		bit taken;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		ch   <= c;
		chars_sent++;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drop the request line and wait until every parsed number has come out or the limit is reached
	task automatic drain(input int limit);
		int waited;
		push <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (outstanding != 0 && waited < limit);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10)
			return CH_DIG0 + 8'(v);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
	endfunction

	function automatic logic [BASE_W-1:0] pick_base();
		case ($urandom_range(9))
			0: return BASE_AUTO;
			1: return 6'd1;
			2: return 6'd2;
			3: return BASE_OCT;
			4: return BASE_DEC;
			5: return BASE_HEX;
			6: return 6'd36;
			7: return 6'd37;
			8: return 6'd63;
			default: return BASE_W'($urandom_range(63));
		endcase
	endfunction

	// Send a well-formed number in the given radix, then a terminator or a random byte
	task automatic send_number(input logic [BASE_W-1:0] base);
		int radix;
		int digits;
		int span;
		repeat ($urandom_range(2)) send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
		case ($urandom_range(2))
			1: send_char(CH_MINUS);
			2: send_char(CH_PLUS);
			default: ;
		endcase
		radix  = base;
		digits = ($urandom_range(9) == 0) ? $urandom_range(24, 15) : $urandom_range(6, 1);
		if (base == BASE_AUTO) begin
			case ($urandom_range(2))
				0: begin
					send_char(CH_DIG0);
					send_char($urandom_range(1) ? CH_LX : CH_UX);
					radix = BASE_HEX;
				end
				1: begin
					send_char(CH_DIG0);
					radix = BASE_OCT;
				end
				default: begin
					send_char(digit_char($urandom_range(9, 1)));
					digits--;
					radix = BASE_DEC;
				end
			endcase
		end else if (base == BASE_HEX && $urandom_range(1)) begin
			send_char(CH_DIG0);
			send_char($urandom_range(1) ? CH_LX : CH_UX);
		end
		span = (radix > 36) ? 36 : radix;
		repeat (digits) send_char(digit_char($urandom_range(span - 1)));
		case ($urandom_range(3))
			0: send_char(CH_NUL);
			1: send_char(CH_COMMA);
			2: send_char(CH_SPACE);
			default: send_char(8'($urandom_range(255)));
		endcase
	endtask

	// Send noise or a broken number
	task automatic send_broken();
		case ($urandom_range(3))
			0: repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)));
			1: begin
				send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
				send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
			end
			2: begin
				send_char(CH_DIG0);
				send_char($urandom_range(1) ? CH_LX : CH_UX);
				send_char(CH_NUL);
			end
			default: begin
				repeat ($urandom_range(3, 1)) send_char(CH_TAB);
				send_char(CH_NUL);
			end
		endcase
	endtask

	// Drain results, idling at random or holding off when asked
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				pop <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
				@(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		int                send_pct[3];
		int                recv_pct[3];
		int                seg_start;
		logic [BASE_W-1:0] base;
		send_pct = '{13, 61, 0};
		recv_pct = '{61, 13, 0};
		arst_n  = 1'b0;
		push    = 1'b0;
		ch      = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blanks and sign, extreme bytes, second sign
		send_text("\t -12");
		send_char(CH_NUL);
		send_char(8'hFF);
		send_text("+-");
		drain(20000);
		// Auto radix: hex prefix, leading zero followed by a non-octal letter
		apb_write(BASE_ADDR, {26'($urandom()), BASE_AUTO});
		send_text("0x1F,0z");
		drain(20000);
		// A write past the last register leaves the radix alone
		apb_write(SPARE_ADDR, 32'd7);
		send_text("-8 ");
		drain(20000);
		// Radix one accepts only zero; a radix above 36 accepts every letter
		apb_write(BASE_ADDR, 32'd1);
		send_text("01.");
		drain(20000);
		apb_write(BASE_ADDR, 32'h3F);
		send_text("zZ9-");

		// Random: three idle profiles, several radix settings in each
		for (int p = 0; p < 3; p++) begin
			send_idle = send_pct[p];
			recv_idle = recv_pct[p];
			for (int seg = 0; seg < 5; seg++) begin
				drain(20000);
				base = pick_base();
				apb_write(BASE_ADDR, {26'($urandom()), base});
				// Stall the result side long enough to back up the input
				if (p == 2 && seg == 0)
					hold_len = 400;
				seg_start = chars_sent;
				while (chars_sent - seg_start < 117) begin
					if ($urandom_range(99) < 85)
						send_number(base);
					else
						send_broken();
				end
			end
		end

		// Run the consumed count into saturation
		drain(20000);
		apb_write(BASE_ADDR, {26'($urandom()), BASE_DEC});
		repeat (65540) send_char(CH_SPACE);
		send_text("5");
		send_char(CH_NUL);

		drain(20000);
		if (mismatches == 0 && outstanding == 0)
			$display("integer_text_parser test passed");
		else
			$display("integer_text_parser test failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/itp_pkg.sv
design/itp_front.sv
design/itp_back.sv
design/integer_text_parser.sv
sim/itp_result_checker.sv
sim/tb_integer_text_parser.sv
